// File: sv/fhd_pkg.sv
// Shared types and constants for the frame header deframer.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package fhd_pkg;

   // Header layout: byte 0 service, 1 detail, 2..3 crc, 4..5 seq, 6..7 ack, 8..11 length.
   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

   localparam int unsigned KIND_W    = 2;
   localparam int unsigned SERVICE_W = 2;
   localparam int unsigned LEN_W     = 32;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BODY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

   // Valid service codes.
   localparam logic [7:0] SVC_DATA    = 8'd1;
   localparam logic [7:0] SVC_COMMAND = 8'd2;
   localparam logic [7:0] SVC_ERROR   = 8'd3;
   localparam logic [SERVICE_W-1:0] SVC_NONE = 2'd0;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_STOP   = 2'd2
   } phase_type;

   typedef struct packed {
      logic                 has_result;
      logic [KIND_W-1:0]    kind;
      logic [SERVICE_W-1:0] service;
      logic [7:0]           detail;
      logic [15:0]          crc_field;
      logic [15:0]          seq_number;
      logic [15:0]          ack_number;
      logic [LEN_W-1:0]     frame_length;
      logic [7:0]           body_byte;
      logic                 last;
   } result_type;

endpackage

// File: sv/frame_header_deframer.sv
// A result appears on rsp_valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; req_stall rises only while a result waits under rsp_stall.
// Reset (synchronous, active high) clears the frame phase, the byte and length counters
// and the output valid; the captured header bytes are not cleared, every one is
// rewritten before it is read.
`timescale 1ns / 1ps

// Top level of the deframer. Depends on fhd_pkg and fhd_core.
// Adds the valid/stall handshake and the result register around the parser.
module frame_header_deframer
   import fhd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_byte,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [SERVICE_W-1:0] rsp_service,
   output logic [7:0]           rsp_detail,
   output logic [15:0]          rsp_crc_field,
   output logic [15:0]          rsp_seq_number,
   output logic [15:0]          rsp_ack_number,
   output logic [LEN_W-1:0]     rsp_frame_length,
   output logic [7:0]           rsp_body_byte,
   output logic                 rsp_last
);

   // The result register is free when it is empty or its item leaves this cycle.
   // Only then may a new byte enter, because that byte may produce a result.
   logic       out_free;
   logic       accept;
   result_type core_result;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign accept    = req_valid && out_free;

   // The parser owns the frame state; it moves only on an accepted item.
   fhd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .in_byte (req_in_byte),
      .result  (core_result)
   );

   // A held result stays put while stalled. A byte that yields no result
   // (header bytes before the last one, or bytes after an error) lets the
   // register drain to empty.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept && core_result.has_result) begin
         rsp_in       = core_result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload needs no reset; it is only looked at while rsp_valid is high.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_service      = rsp_ff.service;
   assign rsp_detail       = rsp_ff.detail;
   assign rsp_crc_field    = rsp_ff.crc_field;
   assign rsp_seq_number   = rsp_ff.seq_number;
   assign rsp_ack_number   = rsp_ff.ack_number;
   assign rsp_frame_length = rsp_ff.frame_length;
   assign rsp_body_byte    = rsp_ff.body_byte;
   assign rsp_last         = rsp_ff.last;

endmodule

// File: sv/fhd_core.sv
// Frame parsing state machine: header capture, length check and body pass-through.
// Depends on fhd_pkg. Produces at most one result for each byte it is handed.
`timescale 1ns / 1ps

module fhd_core
   import fhd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] in_byte,
   output result_type result
);

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] byte_count_ff, byte_count_in;
   logic [LEN_W-1:0] frame_total_ff, frame_total_in;
   logic [7:0]       header_store_ff [HEADER_BYTES];
   logic [7:0]       hdr_next [HEADER_BYTES];
   logic             wr_en;
   logic [HDR_IDX_W-1:0] wr_idx;
   logic [LEN_W-1:0] count_inc;
   logic [LEN_W-1:0] hdr_len;
   logic             svc_ok;
   logic             len_ok;

   assign wr_idx    = byte_count_ff[HDR_IDX_W-1:0];
   assign count_inc = byte_count_ff + LEN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         byte_count_ff  <= '0;
         frame_total_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         frame_total_ff <= frame_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         header_store_ff[wr_idx] <= in_byte;
      end
   end

   always_comb begin
      hdr_next = header_store_ff;
      if (wr_en) begin
         hdr_next[wr_idx] = in_byte;
      end
   end

   assign hdr_len = {hdr_next[11], hdr_next[10], hdr_next[9], hdr_next[8]};
   assign svc_ok  = (hdr_next[0] == SVC_DATA) || (hdr_next[0] == SVC_COMMAND) ||
                    (hdr_next[0] == SVC_ERROR);
   assign len_ok  = hdr_len >= LEN_W'(HEADER_BYTES);

   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      frame_total_in = frame_total_ff;
      wr_en          = 1'b0;

      result.has_result   = 1'b0;
      result.kind         = KIND_HEADER;
      result.service      = svc_ok ? hdr_next[0][SERVICE_W-1:0] : SVC_NONE;
      result.detail       = hdr_next[1];
      result.crc_field    = {hdr_next[3], hdr_next[2]};
      result.seq_number   = {hdr_next[5], hdr_next[4]};
      result.ack_number   = {hdr_next[7], hdr_next[6]};
      result.frame_length = hdr_len;
      result.body_byte    = '0;
      result.last         = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (advance) begin
               wr_en         = 1'b1;
               byte_count_in = count_inc;
               if (count_inc == LEN_W'(HEADER_BYTES)) begin
                  result.has_result = 1'b1;
                  if (!svc_ok || !len_ok) begin
                     result.kind = KIND_ERROR;
                     result.last = 1'b1;
                     phase_in    = PH_STOP;
                  end else begin
                     frame_total_in = hdr_len;
                     if (hdr_len == LEN_W'(HEADER_BYTES)) begin
                        // Header-only frame: the next byte opens a new header.
                        result.last   = 1'b1;
                        byte_count_in = '0;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end
            end
         end
         PH_BODY: begin
            if (advance) begin
               result.has_result = 1'b1;
               result.kind       = KIND_BODY;
               result.body_byte  = in_byte;
               byte_count_in     = count_inc;
               if (count_inc >= frame_total_ff) begin
                  result.last   = 1'b1;
                  phase_in      = PH_HEADER;
                  byte_count_in = '0;
               end
            end
         end
         default: begin
            // Stopped after a framing error: bytes are dropped until reset.
         end
      endcase
   end

endmodule

// File: sv/fhd_checker.sv
// Port-level checks for the frame header deframer, attached by bind.
// Depends on fhd_pkg and on the frame_header_deframer port list.
`timescale 1ns / 1ps

module fhd_checker
   import fhd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [KIND_W-1:0]    rsp_kind,
   input logic [SERVICE_W-1:0] rsp_service,
   input logic                 rsp_last
);

   // Set once an error item has been taken; the block must go silent.
   logic stopped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_kind == KIND_ERROR) begin
         stopped_ff <= 1'b1;
      end
   end

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result register could take an item");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_last)))
      else $error("stalled result changed or vanished");

   a_silent_after_error: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !rsp_valid)
      else $error("result produced after a framing error");

   a_body_has_service: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_BODY) |-> (rsp_service != SVC_NONE))
      else $error("body item without a valid service code");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ERROR) |-> rsp_last)
      else $error("error item not flagged as last");

endmodule

bind frame_header_deframer fhd_checker u_fhd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_kind    (rsp_kind),
   .rsp_service (rsp_service),
   .rsp_last    (rsp_last)
);

// File: test/testbench.sv
// Testbench for frame_header_deframer: a queue-fed byte driver, a result monitor
// and a predictor of the header and body parsing. Depends on fhd_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
   import fhd_pkg::*;

   // A watchdog ends the run after this many cycles in which no item moves on
   // either side. The longest correct quiet spell is the receiver hold-off below.
   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned BYTE_TARGET = 1650;
   // The receiver holds off once, for HOLD_CYCLES, after HOLD_AFTER bytes.
   localparam int unsigned HOLD_AFTER  = 500;
   localparam int unsigned HOLD_CYCLES = 64;
   // Inside this window of cycles neither side idles.
   localparam int unsigned CALM_FROM   = 1000;
   localparam int unsigned CALM_TO     = 1600;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_in_byte = 8'd0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic [SERVICE_W-1:0] rsp_service;
   logic [7:0]           rsp_detail;
   logic [15:0]          rsp_crc_field;
   logic [15:0]          rsp_seq_number;
   logic [15:0]          rsp_ack_number;
   logic [LEN_W-1:0]     rsp_frame_length;
   logic [7:0]           rsp_body_byte;
   logic                 rsp_last;

   frame_header_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_service      (rsp_service),
      .rsp_detail       (rsp_detail),
      .rsp_crc_field    (rsp_crc_field),
      .rsp_seq_number   (rsp_seq_number),
      .rsp_ack_number   (rsp_ack_number),
      .rsp_frame_length (rsp_frame_length),
      .rsp_body_byte    (rsp_body_byte),
      .rsp_last         (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stream bytes still to be offered, and the parser results still owed.
   logic [7:0]  stream_bytes[$];
   result_type  owed_results[$];

   int unsigned cycle_no       = 0;
   int unsigned bytes_accepted = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned mismatch_count = 0;
   int unsigned results_seen   = 0;
   int unsigned hold_left      = 0;
   logic        hold_done      = 1'b0;
   logic        calm;

   assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

   // Appends one byte to the tail of the stream.
   task automatic queue_byte(input logic [7:0] b);
      stream_bytes.insert(stream_bytes.size(), b);
   endtask

   // Appends one result to the tail of the owed list.
   task automatic owe_result(input result_type r);
      owed_results.insert(owed_results.size(), r);
   endtask

   // ------------------------------------------------------------------
   // Predictor. It keeps its own copy of the parser state: the frame phase,
   // the byte count of the current frame, the captured header and the
   // length of the frame being passed through.
   // ------------------------------------------------------------------
   phase_type   frame_phase = PH_HEADER;
   logic [31:0] frame_count = '0;
   logic [31:0] frame_total = '0;
   logic [7:0]  hdr_bytes[HEADER_BYTES];

   // Every result carries the header fields of its frame. A service byte
   // outside the three known codes reads back as no service.
   function automatic result_type with_header(input logic [KIND_W-1:0] kind,
                                              input logic [7:0] body, input logic last);
      result_type r;
      logic [7:0] svc;
      svc            = hdr_bytes[0];
      r.has_result   = 1'b1;
      r.kind         = kind;
      r.service      = (svc >= SVC_DATA && svc <= SVC_ERROR) ? svc[SERVICE_W-1:0] : SVC_NONE;
      r.detail       = hdr_bytes[1];
      r.crc_field    = {hdr_bytes[3], hdr_bytes[2]};
      r.seq_number   = {hdr_bytes[5], hdr_bytes[4]};
      r.ack_number   = {hdr_bytes[7], hdr_bytes[6]};
      r.frame_length = {hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8]};
      r.body_byte    = body;
      r.last         = last;
      return r;
   endfunction

   // Advances the predicted parser by one accepted byte and queues the
   // result that byte produces, if any.
   task automatic deframe_byte(input logic [7:0] b);
      logic [7:0]  svc;
      logic [31:0] len;
      case (frame_phase)
         PH_HEADER: begin
            if (frame_count < HEADER_BYTES) hdr_bytes[frame_count[HDR_IDX_W-1:0]] = b;
            frame_count = frame_count + 1;
            if (frame_count >= HEADER_BYTES) begin
               svc = hdr_bytes[0];
               len = {hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8]};
               if (svc < SVC_DATA || svc > SVC_ERROR || len < HEADER_BYTES) begin
                  // A bad header stops the parser until the next reset.
                  owe_result(with_header(KIND_ERROR, 8'd0, 1'b1));
                  frame_phase = PH_STOP;
               end else if (len == HEADER_BYTES) begin
                  // A header-only frame ends on its header result.
                  frame_total = len;
                  owe_result(with_header(KIND_HEADER, 8'd0, 1'b1));
                  frame_count = '0;
               end else begin
                  frame_total = len;
                  owe_result(with_header(KIND_HEADER, 8'd0, 1'b0));
                  frame_phase = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            frame_count = frame_count + 1;
            if (frame_count >= frame_total) begin
               owe_result(with_header(KIND_BODY, b, 1'b1));
               frame_phase = PH_HEADER;
               frame_count = '0;
            end else begin
               owe_result(with_header(KIND_BODY, b, 1'b0));
            end
         end
         default: begin
            // Stopped: the byte is dropped.
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   task automatic push_header(input logic [7:0] svc, input logic [7:0] detail,
                              input logic [15:0] crc, input logic [15:0] seq,
                              input logic [15:0] ack, input logic [31:0] len);
      queue_byte(svc);
      queue_byte(detail);
      queue_byte(crc[7:0]);
      queue_byte(crc[15:8]);
      queue_byte(seq[7:0]);
      queue_byte(seq[15:8]);
      queue_byte(ack[7:0]);
      queue_byte(ack[15:8]);
      queue_byte(len[7:0]);
      queue_byte(len[15:8]);
      queue_byte(len[23:16]);
      queue_byte(len[31:24]);
   endtask

   task automatic push_random_frame(input logic [7:0] svc, input int unsigned body_len);
      push_header(svc, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  HEADER_BYTES + body_len);
      repeat (body_len) queue_byte(8'($urandom));
   endtask

   task automatic report_mismatch(input string what, input result_type want,
                                  input result_type got);
      if (mismatch_count < 10) begin
         $display("result %0d %s: expected kind %0d svc %0d detail %02h crc %04h seq %04h",
                  results_seen, what, want.kind, want.service, want.detail,
                  want.crc_field, want.seq_number);
         $display("   expected ack %04h len %08h body %02h last %0b",
                  want.ack_number, want.frame_length, want.body_byte, want.last);
         $display("   actual kind %0d svc %0d detail %02h crc %04h seq %04h",
                  got.kind, got.service, got.detail, got.crc_field, got.seq_number);
         $display("   actual ack %04h len %08h body %02h last %0b",
                  got.ack_number, got.frame_length, got.body_byte, got.last);
      end
      mismatch_count = mismatch_count + 1;
   endtask

   // ------------------------------------------------------------------
   // Driver. A new item is loaded only when the slot is empty or the item
   // in it was taken at this edge, so a stalled item holds still. The
   // sender idles at random except inside the calm window and while the
   // receiver holds off, so the block fills up and stalls its input then.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'd0;
      end else begin
         if (req_valid && !req_stall) deframe_byte(req_in_byte);
         if (!req_valid || !req_stall) begin
            if (stream_bytes.size() > 0 &&
                (calm || hold_left > 0 || $urandom_range(99) >= 17)) begin
               req_valid   <= 1'b1;
               req_in_byte <= stream_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && bytes_accepted >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 17);
      end
   end

   // Monitor: every accepted result is checked against the oldest one owed.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.has_result   = 1'b1;
         got.kind         = rsp_kind;
         got.service      = rsp_service;
         got.detail       = rsp_detail;
         got.crc_field    = rsp_crc_field;
         got.seq_number   = rsp_seq_number;
         got.ack_number   = rsp_ack_number;
         got.frame_length = rsp_frame_length;
         got.body_byte    = rsp_body_byte;
         got.last         = rsp_last;
         if (owed_results.size() == 0) begin
            report_mismatch("not expected", '0, got);
         end else begin
            want = owed_results.pop_front();
            if (got.kind !== want.kind || got.service !== want.service ||
                got.detail !== want.detail || got.crc_field !== want.crc_field ||
                got.seq_number !== want.seq_number || got.ack_number !== want.ack_number ||
                got.frame_length !== want.frame_length || got.body_byte !== want.body_byte ||
                got.last !== want.last)
               report_mismatch("mismatch", want, got);
         end
         results_seen = results_seen + 1;
      end
   end

   // Cycle count, accepted byte count and the watchdog.
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (!reset && req_valid && !req_stall) bytes_accepted <= bytes_accepted + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run. A framing error stops the block until reset,
   // and reset is applied only once, so the broken header comes last and
   // everything before it is well formed.
   // ------------------------------------------------------------------
   initial begin
      logic [7:0]  bad_svc;
      logic [31:0] bad_len;
      int unsigned body_len;
      int unsigned pick;

      // Directed: a header-only frame with the detail, crc, seq and ack fields at
      // their top value, then a one-byte body frame with those fields at zero.
      push_header(SVC_COMMAND, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, HEADER_BYTES);
      push_header(SVC_ERROR, 8'h00, 16'h0000, 16'h0000, 16'h0000, HEADER_BYTES + 1);
      queue_byte(8'hFF);

      // Random frames: mostly short bodies, some header-only, a few long.
      while (stream_bytes.size() < BYTE_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 5)       body_len = $urandom_range(300, 120);
         else if (pick < 15) body_len = 0;
         else                body_len = $urandom_range(40, 1);
         push_random_frame(8'($urandom_range(SVC_ERROR, SVC_DATA)), body_len);
      end

      // The closing broken header: a bad service code, a length below the
      // header size, or both. A bad service code comes with any length.
      pick = $urandom_range(2);
      if ($urandom_range(1)) bad_svc = 8'd0;
      else                   bad_svc = 8'($urandom_range(255, 4));
      bad_len = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
      case (pick)
         0: push_header(bad_svc, 8'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), bad_len);
         1: push_header(8'($urandom_range(SVC_ERROR, SVC_DATA)), 8'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom),
                        32'($urandom_range(HEADER_BYTES - 1, 0)));
         default: push_header(bad_svc, 8'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 32'($urandom_range(HEADER_BYTES - 1, 0)));
      endcase
      // Once stopped, the block must swallow whatever follows without a result.
      repeat (40) queue_byte(8'($urandom));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() > 0 || req_valid) @(posedge clock);
      while (owed_results.size() > 0) @(posedge clock);
      // The block answers in the cycle after it accepts a byte; the wait below catches strays.
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
